>>> rtl/core/assert_macros.svh
// assertion helpers
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// a must imply b on the next edge
`define ASSERT_NEXT(label, clk, rst_n, a, b) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
        else $error("assertion failed");

// a must imply b on the same edge
`define ASSERT_SAME(label, clk, rst_n, a, b) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
        else $error("assertion failed");

`endif

>>> rtl/core/cip_pkg.sv
`default_nettype none
package cip_pkg;
    localparam int WORD_BITS = 32;
    localparam int FRAC_BITS = 24;
    localparam int EXP_BITS  = 8;
    // squaring steps after the first exponent bit
    localparam int NSTEP     = EXP_BITS - 2;
    localparam int PROD_BITS = 2 * WORD_BITS;

    typedef logic signed [WORD_BITS-1:0] word_t;
    typedef logic signed [PROD_BITS-1:0] prod_t;

    localparam word_t WMAX = word_t'({1'b0, {(WORD_BITS-1){1'b1}}});
    localparam word_t WMIN = word_t'({1'b1, {(WORD_BITS-1){1'b0}}});

    // saturate a wide signed value to the word
    function automatic word_t sat_p(input prod_t v, output logic ov);
        begin
            ov = 1'b0;
            if (v > prod_t'(WMAX)) begin
                ov = 1'b1;
                sat_p = WMAX;
            end else if (v < prod_t'(WMIN)) begin
                ov = 1'b1;
                sat_p = WMIN;
            end else begin
                sat_p = v[WORD_BITS-1:0];
            end
        end
    endfunction

    function automatic word_t add_s(input word_t a, input word_t b, output logic ov);
        prod_t s;
        begin
            s = prod_t'(a) + prod_t'(b);
            add_s = sat_p(s, ov);
        end
    endfunction

    function automatic word_t sub_s(input word_t a, input word_t b, output logic ov);
        prod_t s;
        begin
            s = prod_t'(a) - prod_t'(b);
            sub_s = sat_p(s, ov);
        end
    endfunction

    // product >>> FRAC_BITS, floor, saturated
    function automatic word_t shr_s(input prod_t p, output logic ov);
        prod_t q;
        begin
            q = p >>> FRAC_BITS;
            shr_s = sat_p(q, ov);
        end
    endfunction
endpackage
`default_nettype wire

>>> rtl/core/complex_integer_power_unit.sv
// Channel | Dir | tdata fields (low bit up)                    | tuser
// s_axis  | in  | base_real[31:0] base_imag[63:32] exponent[71:64] | -
// m_axis  | out | power_real[31:0] power_imag[63:32]           | overflow
//
// One item enters per cycle while m_axis is not stalled. The pipeline is an entry
// stage, six squaring steps of five stages each (sum/diff, square multiply,
// square shift/saturate, multiply by running result, shift/combine), and the
// output register.
// Reset (aresetn low, synchronous) clears all valid bits.
// A stall on m_axis holds the whole pipeline; nothing is lost or repeated.
`default_nettype none
`include "assert_macros.svh"
module complex_integer_power_unit import cip_pkg::*; (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [71:0] s_axis_tdata,  // base_real, base_imag, exponent
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [63:0]      m_axis_tdata,  // power_real, power_imag
    output logic [0:0]       m_axis_tuser   // overflow
);
    localparam int NST = 5 * NSTEP;
    localparam word_t ONE = word_t'(1) <<< FRAC_BITS;

    typedef struct packed {
        word_t                   xt;
        word_t                   yt;
        word_t                   rx;
        word_t                   ry;
        logic [EXP_BITS-1:0]     e;
        logic                    ov;
        // multiply-stage products
        prod_t                   p0;
        prod_t                   p1;
        prod_t                   p2;
        prod_t                   p3;
        prod_t                   p4;
        prod_t                   p5;
        word_t                   w0;
        word_t                   w1;
    } item_t;

    logic  adv;
    logic  [NST:0] vld_reg;
    item_t pipe_reg [NST:0];
    item_t pipe_next [NST:0];
    logic  out_vld_reg;
    word_t out_re_reg, out_im_reg;
    logic  out_ov_reg;

    assign adv           = !out_vld_reg || m_axis_tready;
    assign s_axis_tready = adv;

    // entry stage
    always_comb begin
        item_t it;
        word_t br, bi;
        logic signed [EXP_BITS-1:0] ex;
        it = '0;
        br = s_axis_tdata[WORD_BITS-1:0];
        bi = s_axis_tdata[2*WORD_BITS-1:WORD_BITS];
        ex = s_axis_tdata[2*WORD_BITS+EXP_BITS-1:2*WORD_BITS];
        it.xt = br;
        it.yt = bi;
        it.e  = ex[EXP_BITS-1] ? '0 : ex;
        if (it.e[0]) begin
            it.rx = br;
            it.ry = bi;
        end else begin
            it.rx = ONE;
            it.ry = '0;
        end
        it.e = it.e >> 1;
        pipe_next[0] = it;
    end

    // squaring step stages
    for (genvar g = 1; g <= NST; g++) begin : g_st
        always_comb begin
            item_t it;
            logic o1, o2, o3, o4, o5, o6;
            it = pipe_reg[g-1];
            o1 = 1'b0; o2 = 1'b0; o3 = 1'b0; o4 = 1'b0; o5 = 1'b0; o6 = 1'b0;
            if (it.e != '0) begin
                case ((g - 1) % 5)
                    0: begin
                        it.w0 = add_s(it.xt, it.yt, o1);
                        it.w1 = sub_s(it.xt, it.yt, o2);
                        it.ov = it.ov | o1 | o2;
                    end
                    1: begin
                        it.p0 = prod_t'(it.w0) * prod_t'(it.w1);
                        it.p1 = prod_t'(it.xt) * prod_t'(it.yt);
                    end
                    2: begin
                        it.xt = shr_s(it.p0, o1);
                        it.w0 = shr_s(it.p1, o2);
                        it.yt = add_s(it.w0, it.w0, o3);
                        it.ov = it.ov | o1 | o2 | o3;
                    end
                    3: begin
                        if (it.e[0]) begin
                            it.p2 = prod_t'(it.xt) * prod_t'(it.rx);
                            it.p3 = prod_t'(it.yt) * prod_t'(it.ry);
                            it.p4 = prod_t'(it.ry) * prod_t'(it.xt);
                            it.p5 = prod_t'(it.yt) * prod_t'(it.rx);
                        end
                    end
                    default: begin
                        if (it.e[0]) begin
                            word_t a, b, c, d;
                            a = shr_s(it.p2, o1);
                            b = shr_s(it.p3, o2);
                            c = shr_s(it.p4, o3);
                            d = shr_s(it.p5, o4);
                            it.rx = sub_s(a, b, o5);
                            it.ry = add_s(c, d, o6);
                            it.ov = it.ov | o1 | o2 | o3 | o4 | o5 | o6;
                        end
                        it.e = it.e >> 1;
                    end
                endcase
            end
            pipe_next[g] = it;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg     <= '0;
            out_vld_reg <= 1'b0;
        end else if (adv) begin
            vld_reg     <= {vld_reg[NST-1:0], s_axis_tvalid};
            out_vld_reg <= vld_reg[NST];
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            for (int i = 0; i <= NST; i++) pipe_reg[i] <= pipe_next[i];
            out_re_reg <= pipe_reg[NST].rx;
            out_im_reg <= pipe_reg[NST].ry;
            out_ov_reg <= pipe_reg[NST].ov;
        end
    end

    assign m_axis_tvalid   = out_vld_reg;
    assign m_axis_tdata    = {out_im_reg, out_re_reg};
    assign m_axis_tuser[0] = out_ov_reg;

    `ASSERT_NEXT(a_hold, aclk, aresetn, m_axis_tvalid && !m_axis_tready, m_axis_tvalid)
    `ASSERT_SAME(a_rdy, aclk, aresetn, !m_axis_tvalid, s_axis_tready)
    `ASSERT_NEXT(a_stall, aclk, aresetn, !s_axis_tready, $stable(vld_reg))
endmodule
`default_nettype wire

>>> verif/complex_integer_power_unit_tb.sv
`timescale 1ns / 1ps
module complex_integer_power_unit_tb;
    import cip_pkg::*;

    // one power result as it leaves the block
    typedef struct packed {
        logic [WORD_BITS-1:0] re;
        logic [WORD_BITS-1:0] im;
        logic                 ovf;
    } power_t;

    // directed row: base, exponent, and optionally a typed-in answer
    typedef struct {
        logic [WORD_BITS-1:0] re;
        logic [WORD_BITS-1:0] im;
        logic [EXP_BITS-1:0]  ex;
        bit                   fixed;
        power_t               ans;
    } row_t;

    localparam int          N_RANDOM = 950;
    localparam int          LATENCY  = 32;
    localparam logic [31:0] ONE      = 32'h0100_0000;
    localparam logic [31:0] MAXW     = 32'h7fff_ffff;
    localparam logic [31:0] MINW     = 32'h8000_0000;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [71:0] s_axis_tdata = '0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [63:0] m_axis_tdata;
    logic [0:0]  m_axis_tuser;

    power_t power_q[$];
    int     errors = 0;
    int     checked = 0;
    int     n_ovf = 0;
    bit     feeding_done = 1'b0;
    row_t   rows[$];

    complex_integer_power_unit dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    initial begin
        forever #5 aclk = ~aclk;
    end

    // --- predictor: 128-bit intermediates, saturation to the word ---
    function automatic logic signed [31:0] clip(input logic signed [127:0] v, inout bit ovf);
        if (v > 128'sd2147483647) begin
            ovf = 1'b1;
            return MAXW;
        end
        if (v < -128'sd2147483648) begin
            ovf = 1'b1;
            return MINW;
        end
        return v[31:0];
    endfunction

    function automatic logic signed [31:0] qadd(input logic signed [31:0] a, b, inout bit ovf);
        return clip(128'(a) + 128'(b), ovf);
    endfunction

    function automatic logic signed [31:0] qsub(input logic signed [31:0] a, b, inout bit ovf);
        return clip(128'(a) - 128'(b), ovf);
    endfunction

    // arithmetic shift floors, as required
    function automatic logic signed [31:0] qmul(input logic signed [31:0] a, b, inout bit ovf);
        logic signed [127:0] p;
        p = 128'(a) * 128'(b);
        return clip(p >>> FRAC_BITS, ovf);
    endfunction

    function automatic power_t complex_power(input logic [31:0] br, bi, input logic [7:0] ex);
        logic signed [31:0] xr, xi, rr, ri, t, u;
        logic [7:0] e;
        bit ovf;
        ovf = 1'b0;
        xr = br;
        xi = bi;
        e = ex[7] ? 8'd0 : ex;
        if (e[0]) begin
            rr = xr;
            ri = xi;
        end else begin
            rr = ONE;
            ri = '0;
        end
        e = e >> 1;
        while (e != 0) begin
            t = qmul(qadd(xr, xi, ovf), qsub(xr, xi, ovf), ovf);
            u = qmul(xr, xi, ovf);
            xi = qadd(u, u, ovf);
            xr = t;
            if (e[0]) begin
                t = qsub(qmul(xr, rr, ovf), qmul(xi, ri, ovf), ovf);
                ri = qadd(qmul(ri, xr, ovf), qmul(xi, rr, ovf), ovf);
                rr = t;
            end
            e = e >> 1;
        end
        return '{re: rr, im: ri, ovf: ovf};
    endfunction

    function automatic row_t mk(input logic [31:0] r, i, input logic [7:0] x);
        row_t w;
        w.re = r;
        w.im = i;
        w.ex = x;
        w.fixed = 1'b0;
        w.ans = '0;
        return w;
    endfunction

    function automatic row_t mkf(input logic [31:0] r, i, input logic [7:0] x,
                                 input logic [31:0] pr, pi, input logic ov);
        row_t w;
        w = mk(r, i, x);
        w.fixed = 1'b1;
        w.ans = '{re: pr, im: pi, ovf: ov};
        return w;
    endfunction

    // idle length: usually none or short, sometimes long
    function automatic int gap_len();
        int k;
        k = $urandom_range(0, 99);
        if (k < 50) return 0;
        if (k < 92) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // tvalid stays high between back-to-back transfers
    task automatic send(input logic [31:0] r, i, input logic [7:0] x, input bit chk,
                        input power_t ans);
        int g;
        g = gap_len();
        if (g > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (g) @(posedge aclk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {x, i, r};
        @(posedge aclk);
        while (!s_axis_tready) @(posedge aclk);
        power_q.push_back(chk ? ans : complex_power(r, i, x));
    endtask

    // bases mostly near unit magnitude so powers stay in range
    function automatic logic [31:0] rnd_base();
        int k;
        k = $urandom_range(0, 9);
        if (k < 3) return $urandom;
        if (k < 6) return 32'($signed($urandom_range(0, 32'h0200_0000)) - 32'sh0100_0000);
        if (k < 8) return 32'($signed($urandom_range(0, 32'h0060_0000)) + 32'sh00d0_0000);
        return 32'($signed($urandom_range(0, 32'h0400_0000)) - 32'sh0200_0000);
    endfunction

    // stimulus
    initial begin
        row_t w;
        logic [7:0] x;
        rows.push_back(mkf(ONE, 32'h0, 8'd0, ONE, 32'h0, 1'b0));
        rows.push_back(mkf(32'h1234_5678, 32'h9abc_def0, 8'd0, ONE, 32'h0, 1'b0));
        // negative exponent counts as zero
        rows.push_back(mkf(MAXW, MINW, 8'h80, ONE, 32'h0, 1'b0));
        rows.push_back(mkf(MINW, MAXW, 8'hff, ONE, 32'h0, 1'b0));
        rows.push_back(mkf(MAXW, MINW, 8'd1, MAXW, MINW, 1'b0));
        rows.push_back(mkf(MINW, MAXW, 8'd1, MINW, MAXW, 1'b0));
        rows.push_back(mkf(32'h0, 32'h0, 8'd127, 32'h0, 32'h0, 1'b0));
        rows.push_back(mkf(32'hffff_ffff, 32'hffff_ffff, 8'd1, 32'hffff_ffff, 32'hffff_ffff, 1'b0));
        // saturating squares, then assorted other bases and exponents
        rows.push_back(mkf(MAXW, 32'h0, 8'd2, MAXW, 32'h0, 1'b1));
        rows.push_back(mk(MINW, MINW, 8'd2));
        rows.push_back(mk(MAXW, MAXW, 8'd127));
        rows.push_back(mk(MINW, 32'h0, 8'd3));
        rows.push_back(mk(32'h0, ONE, 8'd2));
        rows.push_back(mk(32'h0, ONE, 8'd127));
        rows.push_back(mk(32'hff00_0000, 32'h0, 8'd126));
        rows.push_back(mk(32'h0100_0001, 32'h0000_0003, 8'd64));
        rows.push_back(mk(32'h00b5_04f3, 32'h00b5_04f3, 8'd8));
        rows.push_back(mk(32'hff4a_fb0d, 32'h00b5_04f3, 8'd5));
        rows.push_back(mk(32'h0000_0001, 32'hffff_ffff, 8'd2));
        rows.push_back(mk(32'h0200_0000, 32'hfe00_0000, 8'd7));
        rows.push_back(mk(32'h5555_5555, 32'haaaa_aaaa, 8'd85));

        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (rows[n]) begin
            w = rows[n];
            send(w.re, w.im, w.ex, w.fixed, w.ans);
        end

        for (int n = 0; n < N_RANDOM; n++) begin
            // exponents mostly small, every bit pattern still reached
            case ($urandom_range(0, 9))
                0, 1:    x = 8'($urandom);
                2:       x = 8'd127 - 8'($urandom_range(0, 3));
                default: x = 8'($urandom_range(0, 12));
            endcase
            send(rnd_base(), rnd_base(), x, 1'b0, '0);
        end
        s_axis_tvalid <= 1'b0;
        feeding_done = 1'b1;
    end

    // receiver: random back-pressure, check each transfer
    initial begin
        power_t got, want;
        int g;
        @(posedge aresetn);
        forever begin
            g = gap_len();
            if (g > 0) begin
                m_axis_tready <= 1'b0;
                repeat (g) @(posedge aclk);
            end
            m_axis_tready <= 1'b1;
            @(posedge aclk);
            while (!m_axis_tvalid) @(posedge aclk);
            got = '{re: m_axis_tdata[31:0], im: m_axis_tdata[63:32], ovf: m_axis_tuser[0]};
            if (power_q.size() == 0) begin
                errors++;
                $display("%0t: unexpected result re=%h im=%h ovf=%b",
                         $time, got.re, got.im, got.ovf);
            end else begin
                want = power_q.pop_front();
                checked++;
                if (got.ovf) n_ovf++;
                if (got.re !== want.re) begin
                    errors++;
                    $display("%0t: power_real expected %h actual %h", $time, want.re, got.re);
                end
                if (got.im !== want.im) begin
                    errors++;
                    $display("%0t: power_imag expected %h actual %h", $time, want.im, got.im);
                end
                if (got.ovf !== want.ovf) begin
                    errors++;
                    $display("%0t: overflow expected %b actual %b", $time, want.ovf, got.ovf);
                end
            end
        end
    end

    // end of run
    initial begin
        wait (feeding_done);
        while (power_q.size() != 0) @(posedge aclk);
        repeat (LATENCY * 2) @(posedge aclk);
        if (power_q.size() != 0) errors++;
        $display("Checked %0d power results, %0d of them saturated.", checked, n_ovf);
        if (errors == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

    // watchdog for a run of roughly 1000 items
    initial begin
        #5ms;
        $display("Timeout after %0t", $time);
        $display("Testbench completed WITH ERRORS");
        $finish;
    end
endmodule
